// File: rtl/euler_to_homogeneous_transform_macros.svh
// Assertion macros shared by the RTL of euler_to_homogeneous_transform.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef EULER_TO_HOMOGENEOUS_TRANSFORM_MACROS_SVH
`define EULER_TO_HOMOGENEOUS_TRANSFORM_MACROS_SVH
`ifndef SYNTHESIS
`define ETH_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
`define ETH_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ETH_ASSERT_NOW(lbl, pre, post)
`define ETH_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// File: rtl/eth_pkg.sv
// Types, constants and arithmetic helpers for euler_to_homogeneous_transform.
// No dependencies.
package eth_pkg;

  typedef logic signed [15:0] ang_t;
  typedef logic signed [15:0] trig_t;
  typedef logic signed [31:0] q16_t;

  localparam int SINCOS_LAT = 8;

  localparam logic signed [16:0] ANG_PI      = 17'sd25736;
  localparam logic signed [16:0] ANG_HALF_PI = 17'sd12868;
  localparam logic [30:0]        Q30_ONE     = 31'h4000_0000;
  localparam logic [15:0]        Q14_ONE     = 16'd16384;

  // floor(x / d) = (x * ceil(2^k / d)) >> k, exact for x < 2^32
  localparam logic [5:0]  SH_42 = 6'd38;
  localparam logic [5:0]  SH_56 = 6'd38;
  localparam logic [5:0]  SH_20 = 6'd37;
  localparam logic [5:0]  SH_30 = 6'd37;
  localparam logic [5:0]  SH_6  = 6'd35;
  localparam logic [5:0]  SH_12 = 6'd36;
  localparam logic [32:0] RCP_42 = 33'(((65'd1 << 38) + 65'd41) / 65'd42);
  localparam logic [32:0] RCP_56 = 33'(((65'd1 << 38) + 65'd55) / 65'd56);
  localparam logic [32:0] RCP_20 = 33'(((65'd1 << 37) + 65'd19) / 65'd20);
  localparam logic [32:0] RCP_30 = 33'(((65'd1 << 37) + 65'd29) / 65'd30);
  localparam logic [32:0] RCP_6  = 33'(((65'd1 << 35) + 65'd5) / 65'd6);
  localparam logic [32:0] RCP_12 = 33'(((65'd1 << 36) + 65'd11) / 65'd12);

  function automatic logic [31:0] recip_div(input logic [31:0] x, input logic [32:0] m,
                                            input logic [5:0] sh);
    logic [64:0] prod;
    prod = {33'b0, x} * {32'b0, m};
    return 32'(prod >> sh);
  endfunction

  function automatic logic [31:0] mulq30(input logic [31:0] x, input logic [30:0] p);
    logic [62:0] prod;
    prod = {31'b0, x} * {32'b0, p};
    return prod[61:30];
  endfunction

endpackage

// File: rtl/eth_sincos.sv
// Pipelined fixed-point sine/cosine of one Q3.13 angle, Q2.14 results.
// Depends on eth_pkg; the pipeline advances only when en is high.
module eth_sincos (
  input  logic          clk,
  input  logic          en,
  input  eth_pkg::ang_t angle,
  output eth_pkg::trig_t sin_q,
  output eth_pkg::trig_t cos_q
);
  import eth_pkg::*;

  typedef struct packed {
    logic [13:0] a;
    logic        sn;
    logic        cn;
    logic [31:0] x2;
  } ctx_t;

  ctx_t ctx_nxt;
  ctx_t ctx_r [1:7];

  logic [31:0] ts2_r, tc2_r, ps3_r, pc3_r, ts4_r, tc4_r, ps5_r, pc5_r, ts6_r, tc6_r;
  logic [30:0] sm7_r;
  logic [31:0] pc7_r;
  trig_t       sin_r, cos_r;
  trig_t       sin_nxt, cos_nxt;

  logic signed [16:0] t_ext, t_red, t_mag;
  logic               cn_c;

  always_comb begin
    t_ext = 17'(angle);
    cn_c  = 1'b0;
    t_red = t_ext;
    if (t_ext > ANG_HALF_PI) begin
      t_red = ANG_PI - t_ext;
      cn_c  = 1'b1;
    end else if (t_ext < -ANG_HALF_PI) begin
      t_red = -ANG_PI - t_ext;
      cn_c  = 1'b1;
    end
    t_mag      = t_red[16] ? -t_red : t_red;
    ctx_nxt.a  = t_mag[13:0];
    ctx_nxt.sn = t_red[16];
    ctx_nxt.cn = cn_c;
    ctx_nxt.x2 = {28'({14'b0, t_mag[13:0]} * {14'b0, t_mag[13:0]}), 4'b0};
  end

  logic [31:0] sm_sum, cm_sum;
  logic [30:0] cd, cm;
  logic [15:0] sm_q, cm_q;

  always_comb begin
    cd      = pc7_r[31:1];
    cm      = (cd >= Q30_ONE) ? 31'd0 : Q30_ONE - cd;
    sm_sum  = {1'b0, sm7_r} + 32'd32768;
    cm_sum  = {1'b0, cm} + 32'd32768;
    sm_q    = (sm_sum[31:16] > Q14_ONE) ? Q14_ONE : sm_sum[31:16];
    cm_q    = (cm_sum[31:16] > Q14_ONE) ? Q14_ONE : cm_sum[31:16];
    sin_nxt = ctx_r[7].sn ? -trig_t'(sm_q) : trig_t'(sm_q);
    cos_nxt = ctx_r[7].cn ? -trig_t'(cm_q) : trig_t'(cm_q);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_r[1] <= ctx_nxt;
      for (int i = 2; i <= 7; i++) ctx_r[i] <= ctx_r[i-1];
      ts2_r <= recip_div(ctx_r[1].x2, RCP_42, SH_42);
      tc2_r <= recip_div(ctx_r[1].x2, RCP_56, SH_56);
      ps3_r <= mulq30(ctx_r[2].x2, Q30_ONE - ts2_r[30:0]);
      pc3_r <= mulq30(ctx_r[2].x2, Q30_ONE - tc2_r[30:0]);
      ts4_r <= recip_div(ps3_r, RCP_20, SH_20);
      tc4_r <= recip_div(pc3_r, RCP_30, SH_30);
      ps5_r <= mulq30(ctx_r[4].x2, Q30_ONE - ts4_r[30:0]);
      pc5_r <= mulq30(ctx_r[4].x2, Q30_ONE - tc4_r[30:0]);
      ts6_r <= recip_div(ps5_r, RCP_6, SH_6);
      tc6_r <= recip_div(pc5_r, RCP_12, SH_12);
      sm7_r <= 31'(mulq30({1'b0, ctx_r[6].a, 17'b0}, Q30_ONE - ts6_r[30:0]));
      pc7_r <= mulq30(ctx_r[6].x2, Q30_ONE - tc6_r[30:0]);
      sin_r <= sin_nxt;
      cos_r <= cos_nxt;
    end
  end

  assign sin_q = sin_r;
  assign cos_q = cos_r;

endmodule

// File: rtl/euler_to_homogeneous_transform.sv
// Top level: Euler angles and translation to the upper 3x4 homogeneous transform.
// Depends on eth_pkg, eth_sincos and euler_to_homogeneous_transform_macros.svh.
//
//   channel | ports                 | handshake
//   input   | in_*  angles, shifts   | in_valid / in_ready
//   result  | out_* rotation, trans  | out_valid / out_ready
//   config  | cfg_* offsets x, y, z  | cfg_we, no wait
//
// One request per cycle sustained while the output is not stalled. Depth is set by the
// sine/cosine Horner chain (8 stages) plus 4 stages of matrix products and rounding.
// Synchronous active-low reset clears valid bits and offsets.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
`include "euler_to_homogeneous_transform_macros.svh"
module euler_to_homogeneous_transform (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  eth_pkg::ang_t        in_pitch_angle,
  input  eth_pkg::ang_t        in_roll_angle,
  input  eth_pkg::ang_t        in_yaw_angle,
  input  eth_pkg::q16_t        in_shift_x,
  input  eth_pkg::q16_t        in_shift_y,
  input  eth_pkg::q16_t        in_shift_z,
  output logic                 out_valid,
  input  logic                 out_ready,
  output eth_pkg::trig_t       out_rot_00,
  output eth_pkg::trig_t       out_rot_01,
  output eth_pkg::trig_t       out_rot_02,
  output eth_pkg::trig_t       out_rot_10,
  output eth_pkg::trig_t       out_rot_11,
  output eth_pkg::trig_t       out_rot_12,
  output eth_pkg::trig_t       out_rot_20,
  output eth_pkg::trig_t       out_rot_21,
  output eth_pkg::trig_t       out_rot_22,
  output eth_pkg::q16_t        out_trans_x,
  output eth_pkg::q16_t        out_trans_y,
  output eth_pkg::q16_t        out_trans_z,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_wdata
);
  import eth_pkg::*;

  localparam int NPIPE = SINCOS_LAT + 3;

  typedef enum logic [1:0] {
    REG_OFFSET_X = 2'd0,
    REG_OFFSET_Y = 2'd1,
    REG_OFFSET_Z = 2'd2
  } reg_idx_t;

  typedef logic signed [29:0] pr_t;
  typedef logic signed [44:0] q42_t;

  typedef struct packed {
    q16_t x;
    q16_t y;
    q16_t z;
  } trans_t;

  function automatic pr_t smul16(input trig_t x, input trig_t y);
    logic signed [31:0] f;
    f = x * y;
    return pr_t'(f[29:0]);
  endfunction

  function automatic q42_t smul30(input pr_t x, input trig_t y);
    logic signed [45:0] f;
    f = x * y;
    return q42_t'(f[44:0]);
  endfunction

  function automatic q42_t shl14(input pr_t x);
    q42_t e;
    e = x;
    return e <<< 14;
  endfunction

  function automatic trig_t rnd_q42(input q42_t v);
    logic [44:0] m;
    logic [44:0] s;
    logic [15:0] r;
    m = v[44] ? 45'(-v) : 45'(v);
    s = m + 45'd134217728;
    r = (s[44:28] > 17'(Q14_ONE)) ? Q14_ONE : s[43:28];
    return v[44] ? -trig_t'(r) : trig_t'(r);
  endfunction

  function automatic q16_t sat_add(input q16_t a, input q16_t b);
    logic signed [32:0] s;
    s = 33'(a) + 33'(b);
    if (s[32] != s[31]) return s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    return q16_t'(s[31:0]);
  endfunction

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  q16_t off_x_r, off_y_r, off_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_x_r <= '0;
      off_y_r <= '0;
      off_z_r <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_OFFSET_X: off_x_r <= cfg_wdata;
        REG_OFFSET_Y: off_y_r <= cfg_wdata;
        REG_OFFSET_Z: off_z_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  trig_t sp, cp, sr, cr, sy, cy;

  eth_sincos u_pitch (.clk(clk), .en(en), .angle(in_pitch_angle), .sin_q(sp), .cos_q(cp));
  eth_sincos u_roll  (.clk(clk), .en(en), .angle(in_roll_angle),  .sin_q(sr), .cos_q(cr));
  eth_sincos u_yaw   (.clk(clk), .en(en), .angle(in_yaw_angle),   .sin_q(sy), .cos_q(cy));

  logic   v_r [0:NPIPE-1];
  trans_t tr_r [0:NPIPE-1];
  logic   out_valid_r;
  trans_t out_tr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NPIPE; i++) v_r[i] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int i = 1; i < NPIPE; i++) v_r[i] <= v_r[i-1];
      out_valid_r <= v_r[NPIPE-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tr_r[0] <= '{x: sat_add(in_shift_x, off_x_r), y: sat_add(in_shift_y, off_y_r),
                   z: sat_add(in_shift_z, off_z_r)};
      for (int i = 1; i < NPIPE; i++) tr_r[i] <= tr_r[i-1];
      out_tr_r <= tr_r[NPIPE-1];
    end
  end

  // pair products, then triple products, then Q42 sums, then rounding
  pr_t   cycr_r, sysp_r, cysr_r, sycp_r, crcp_r, crsp_r, sycr_r, sysr_r, cysp_r, cycp_r;
  trig_t sp1_r, cp1_r, sr1_r, sr2_r;
  pr_t   cycr2_r, sysp2_r, sycp2_r, crcp2_r, crsp2_r, sycr2_r, cysp2_r, cycp2_r;
  q42_t  cysrcp_r, cysrsp_r, sysrcp_r, sysrsp_r;
  q42_t  e_r [0:8];
  trig_t rot_r [0:8];

  always_ff @(posedge clk) begin
    if (en) begin
      cycr_r <= smul16(cy, cr);
      sysp_r <= smul16(sy, sp);
      cysr_r <= smul16(cy, sr);
      sycp_r <= smul16(sy, cp);
      crcp_r <= smul16(cr, cp);
      crsp_r <= smul16(cr, sp);
      sycr_r <= smul16(sy, cr);
      sysr_r <= smul16(sy, sr);
      cysp_r <= smul16(cy, sp);
      cycp_r <= smul16(cy, cp);
      sp1_r  <= sp;
      cp1_r  <= cp;
      sr1_r  <= sr;

      cysrcp_r <= smul30(cysr_r, cp1_r);
      cysrsp_r <= smul30(cysr_r, sp1_r);
      sysrcp_r <= smul30(sysr_r, cp1_r);
      sysrsp_r <= smul30(sysr_r, sp1_r);
      cycr2_r  <= cycr_r;
      sysp2_r  <= sysp_r;
      sycp2_r  <= sycp_r;
      crcp2_r  <= crcp_r;
      crsp2_r  <= crsp_r;
      sycr2_r  <= sycr_r;
      cysp2_r  <= cysp_r;
      cycp2_r  <= cycp_r;
      sr2_r    <= sr1_r;

      e_r[0] <= shl14(cycr2_r);
      e_r[1] <= shl14(sysp2_r) - cysrcp_r;
      e_r[2] <= cysrsp_r + shl14(sycp2_r);
      e_r[3] <= q42_t'(sr2_r) <<< 28;
      e_r[4] <= shl14(crcp2_r);
      e_r[5] <= -shl14(crsp2_r);
      e_r[6] <= -shl14(sycr2_r);
      e_r[7] <= sysrcp_r + shl14(cysp2_r);
      e_r[8] <= shl14(cycp2_r) - sysrsp_r;

      for (int i = 0; i < 9; i++) rot_r[i] <= rnd_q42(e_r[i]);
    end
  end

  assign out_valid   = out_valid_r;
  assign out_rot_00  = rot_r[0];
  assign out_rot_01  = rot_r[1];
  assign out_rot_02  = rot_r[2];
  assign out_rot_10  = rot_r[3];
  assign out_rot_11  = rot_r[4];
  assign out_rot_12  = rot_r[5];
  assign out_rot_20  = rot_r[6];
  assign out_rot_21  = rot_r[7];
  assign out_rot_22  = rot_r[8];
  assign out_trans_x = out_tr_r.x;
  assign out_trans_y = out_tr_r.y;
  assign out_trans_z = out_tr_r.z;

  `ETH_ASSERT_NOW(a_stall_blocks_in, out_valid && !out_ready, !in_ready)
  `ETH_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, v_r[0])
  `ETH_ASSERT_NOW(a_rot11_range, out_valid, (out_rot_11 <= 16'sd16384) && (out_rot_11 >= -16'sd16384))

endmodule
